FILE: hdl/rhsl_pkg.sv
// ============================================================================
// rhsl_pkg
// Shared types, constants and arithmetic helpers of the RGB to HSL converter.
// ============================================================================
package rhsl_pkg;

    // Field widths.
    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int Q_W    = 16;

    // Divider lanes: quotient bits, divisor width and bits retired per stage.
    localparam int QN_W      = 18;
    localparam int DEN_W     = 11;
    localparam int NUMX_W    = DEN_W + Q_W;
    localparam int DIV_STEPS = 3;

    // Pipeline stages.
    localparam int STG_DEC       = 0;
    localparam int STG_PREP      = 1;
    localparam int STG_DIV_FIRST = 2;
    localparam int STG_DIV_LAST  = STG_DIV_FIRST + QN_W / DIV_STEPS - 2;
    localparam int STG_OUT       = STG_DIV_LAST + 1;
    localparam int NUM_STG       = STG_OUT + 1;

    // Lane indexes.
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;
    localparam int LANE_LIG = 2;
    localparam int NUM_LANE = 3;

    localparam logic [DEN_W-1:0] LIG_DEN = 11'd510;

    // Configuration port.
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_LSB = 2;

    typedef enum logic [APB_ADDR_W-REG_IDX_LSB-1:0] {
        REG_INPUT_FORMAT = 1'b0
    } reg_idx_t;

    typedef enum logic {
        FMT_RGB888 = 1'b0,
        FMT_RGB565 = 1'b1
    } pix_fmt_t;

    typedef enum logic [1:0] {
        CH_R = 2'd0,
        CH_G = 2'd1,
        CH_B = 2'd2
    } max_ch_t;

    // One restoring divider lane. The numerator bits still to be consumed sit
    // at the top of qn, and quotient bits enter at its bottom.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QN_W-1:0]  qn;
        logic [DEN_W-1:0] den;
    } lane_t;

    // Sets up round(num * 65536 / den) with halves rounded up.
    function automatic lane_t lane_init(logic [DEN_W-1:0] num, logic [DEN_W-1:0] den);
        lane_t              l;
        logic [NUMX_W-1:0]  n;
        n     = {num, {Q_W{1'b0}}} + NUMX_W'(den >> 1);
        l.rem = DEN_W'(n[NUMX_W-1:QN_W]);
        l.qn  = n[QN_W-1:0];
        l.den = den;
        return l;
    endfunction

    function automatic lane_t div_steps(lane_t l);
        lane_t          o;
        logic [DEN_W:0] t;
        o = l;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t    = {o.rem, o.qn[QN_W-1]};
            o.qn = {o.qn[QN_W-2:0], 1'b0};
            if (t >= {1'b0, o.den}) begin
                t       = t - {1'b0, o.den};
                o.qn[0] = 1'b1;
            end
            o.rem = t[DEN_W-1:0];
        end
        return o;
    endfunction

    function automatic logic [Q_W-1:0] sat_q16(logic [QN_W-1:0] q);
        return (q[QN_W-1:Q_W] != '0) ? {Q_W{1'b1}} : q[Q_W-1:0];
    endfunction

endpackage

FILE: hdl/rgb_to_hsl_converter_top.sv
// ============================================================================
// rgb_to_hsl_converter_top
// Pipelined conversion of one packed RGB888 or RGB565 pixel to Q0.16 HSL.
// ============================================================================
// Usage:
//   The pixel channel (pixel, pix_valid, pix_ready) takes one item per clock;
//   while no stall backs up the pipeline; the result channel (hue, saturation,
//   lightness, hsl_valid, hsl_ready) delivers one item per pixel, in order.
//   Both use valid/ready handshakes. The APB port holds input_format at
//   address 0 (0 = RGB888, 1 = RGB565); change it only while no pixel is in
//   flight.
//   The pipeline has one decode stage, one setup stage, five divider stages
//   and an output stage that retires the last quotient bits. Three restoring
//   divider lanes (hue, saturation, lightness) each retire three quotient
//   bits per stage.
//   Reset empties the pipeline and selects RGB888.
//   When the receiver stalls, each stage holds its item; empty stages still
//   fill, so the block keeps accepting until all eight stages are occupied,
//   and nothing is lost or repeated.
// ============================================================================
module rgb_to_hsl_converter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rhsl_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic [rhsl_pkg::PIX_W-1:0]            pixel,
    input  logic                                  pix_valid,
    output logic                                  pix_ready,
    output logic [rhsl_pkg::Q_W-1:0]              hue,
    output logic [rhsl_pkg::Q_W-1:0]              saturation,
    output logic [rhsl_pkg::Q_W-1:0]              lightness,
    output logic                                  hsl_valid,
    input  logic                                  hsl_ready
);

    localparam int CW = rhsl_pkg::CH_W;
    localparam int DW = rhsl_pkg::DEN_W;
    localparam int NS = rhsl_pkg::NUM_STG;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic fmt_reg;
    logic cfg_wr;
    logic cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (rhsl_pkg::reg_idx_t'(paddr[rhsl_pkg::APB_ADDR_W-1:rhsl_pkg::REG_IDX_LSB])
                      == rhsl_pkg::REG_INPUT_FORMAT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? {31'b0, fmt_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= rhsl_pkg::FMT_RGB888;
        end
        else if (cfg_wr)
        begin
            fmt_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control
    // ------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] ready_s;

    // A stage can take an item when it is empty or its item moves on.
    always_comb
    begin
        ready_s[NS-1] = !v_reg[NS-1] || hsl_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ready_s[k] = !v_reg[k] || ready_s[k+1];
        end
    end

    assign pix_ready = ready_s[rhsl_pkg::STG_DEC];
    assign hsl_valid = v_reg[rhsl_pkg::STG_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ready_s[0])
            begin
                v_reg[0] <= pix_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (ready_s[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: unpack, maximum, minimum
    // ------------------------------------------------------------------
    logic [CW-1:0] r_in, g_in, b_in, mx_in, mn_in;
    rhsl_pkg::max_ch_t ch_in;

    always_comb
    begin
        if (rhsl_pkg::pix_fmt_t'(fmt_reg) == rhsl_pkg::FMT_RGB565)
        begin
            r_in = {pixel[15:11], pixel[15:13]};
            g_in = {pixel[10:5], pixel[10:9]};
            b_in = {pixel[4:0], pixel[4:2]};
        end
        else
        begin
            r_in = pixel[23:16];
            g_in = pixel[15:8];
            b_in = pixel[7:0];
        end

        // Red wins ties, then green.
        if (r_in >= g_in && r_in >= b_in)
        begin
            ch_in = rhsl_pkg::CH_R;
            mx_in = r_in;
        end
        else if (g_in >= b_in)
        begin
            ch_in = rhsl_pkg::CH_G;
            mx_in = g_in;
        end
        else
        begin
            ch_in = rhsl_pkg::CH_B;
            mx_in = b_in;
        end

        mn_in = r_in;
        if (g_in < mn_in)
        begin
            mn_in = g_in;
        end
        if (b_in < mn_in)
        begin
            mn_in = b_in;
        end
    end

    logic [CW-1:0] r_reg, g_reg, b_reg, mx_reg, mn_reg;
    rhsl_pkg::max_ch_t ch_reg;

    always_ff @(posedge clk)
    begin
        if (ready_s[rhsl_pkg::STG_DEC] && pix_valid)
        begin
            r_reg  <= r_in;
            g_reg  <= g_in;
            b_reg  <= b_in;
            mx_reg <= mx_in;
            mn_reg <= mn_in;
            ch_reg <= ch_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hue numerator, denominators, divider setup
    // ------------------------------------------------------------------
    logic [CW-1:0] d;
    logic [CW:0]   sum;
    logic [CW:0]   den_s;
    logic [DW-1:0] d6;
    logic [DW-1:0] n_hue;

    always_comb
    begin
        d     = mx_reg - mn_reg;
        sum   = {1'b0, mx_reg} + {1'b0, mn_reg};
        d6    = {1'b0, d, 2'b0} + {2'b0, d, 1'b0};
        den_s = (sum <= 9'd255) ? sum : (9'd510 - sum);

        // The green and blue sums never go negative, so modular 11-bit
        // arithmetic gives the exact value.
        unique case (ch_reg)
            rhsl_pkg::CH_R:
            begin
                if (g_reg >= b_reg)
                begin
                    n_hue = DW'(g_reg - b_reg);
                end
                else
                begin
                    n_hue = d6 - DW'(b_reg - g_reg);
                end
            end
            rhsl_pkg::CH_G:
            begin
                n_hue = {2'b0, d, 1'b0} + DW'(b_reg) - DW'(r_reg);
            end
            rhsl_pkg::CH_B:
            begin
                n_hue = {1'b0, d, 2'b0} + DW'(r_reg) - DW'(g_reg);
            end
            default:
            begin
                n_hue = '0;
            end
        endcase
    end

    rhsl_pkg::lane_t lane_reg [rhsl_pkg::STG_PREP:rhsl_pkg::STG_DIV_LAST][rhsl_pkg::NUM_LANE];
    logic            gray_reg [rhsl_pkg::STG_PREP:rhsl_pkg::STG_DIV_LAST];

    always_ff @(posedge clk)
    begin
        if (ready_s[rhsl_pkg::STG_PREP] && v_reg[rhsl_pkg::STG_DEC])
        begin
            lane_reg[rhsl_pkg::STG_PREP][rhsl_pkg::LANE_HUE] <= rhsl_pkg::lane_init(n_hue, d6);
            lane_reg[rhsl_pkg::STG_PREP][rhsl_pkg::LANE_SAT] <=
                rhsl_pkg::lane_init(DW'(d), DW'(den_s));
            lane_reg[rhsl_pkg::STG_PREP][rhsl_pkg::LANE_LIG] <=
                rhsl_pkg::lane_init(DW'(sum), rhsl_pkg::LIG_DEN);
            gray_reg[rhsl_pkg::STG_PREP] <= (d == '0);
        end
    end

    // ------------------------------------------------------------------
    // Divider stages
    // ------------------------------------------------------------------
    for (genvar k = rhsl_pkg::STG_DIV_FIRST; k <= rhsl_pkg::STG_DIV_LAST; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (ready_s[k] && v_reg[k-1])
            begin
                for (int j = 0; j < rhsl_pkg::NUM_LANE; j++)
                begin
                    lane_reg[k][j] <= rhsl_pkg::div_steps(lane_reg[k-1][j]);
                end
                gray_reg[k] <= gray_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: last quotient bits, saturation, gray override
    // ------------------------------------------------------------------
    rhsl_pkg::lane_t fin_hue, fin_sat, fin_lig;
    logic [rhsl_pkg::Q_W-1:0] hue_reg, saturation_reg, lightness_reg;

    assign fin_hue = rhsl_pkg::div_steps(lane_reg[rhsl_pkg::STG_DIV_LAST][rhsl_pkg::LANE_HUE]);
    assign fin_sat = rhsl_pkg::div_steps(lane_reg[rhsl_pkg::STG_DIV_LAST][rhsl_pkg::LANE_SAT]);
    assign fin_lig = rhsl_pkg::div_steps(lane_reg[rhsl_pkg::STG_DIV_LAST][rhsl_pkg::LANE_LIG]);

    always_ff @(posedge clk)
    begin
        if (ready_s[rhsl_pkg::STG_OUT] && v_reg[rhsl_pkg::STG_DIV_LAST])
        begin
            if (gray_reg[rhsl_pkg::STG_DIV_LAST])
            begin
                hue_reg        <= '0;
                saturation_reg <= '0;
            end
            else
            begin
                hue_reg        <= rhsl_pkg::sat_q16(fin_hue.qn);
                saturation_reg <= rhsl_pkg::sat_q16(fin_sat.qn);
            end
            lightness_reg <= rhsl_pkg::sat_q16(fin_lig.qn);
        end
    end

    assign hue        = hue_reg;
    assign saturation = saturation_reg;
    assign lightness  = lightness_reg;

`ifndef SYNTHESIS
    // An accepted pixel always lands in the decode stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> v_reg[rhsl_pkg::STG_DEC])
        else $error("accepted pixel did not enter the decode stage");

    // The first divider stage, when full and unable to move, keeps its item and its lightness lane.
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[rhsl_pkg::STG_DIV_FIRST] && !ready_s[rhsl_pkg::STG_DIV_FIRST]
        |=> v_reg[rhsl_pkg::STG_DIV_FIRST]
            && $stable(lane_reg[rhsl_pkg::STG_DIV_FIRST][rhsl_pkg::LANE_LIG]))
        else $error("stalled divider stage lost or changed its item");

    // The partial remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[rhsl_pkg::STG_DIV_FIRST]
        && lane_reg[rhsl_pkg::STG_DIV_FIRST][rhsl_pkg::LANE_SAT].den != '0
        |-> lane_reg[rhsl_pkg::STG_DIV_FIRST][rhsl_pkg::LANE_SAT].rem
            < lane_reg[rhsl_pkg::STG_DIV_FIRST][rhsl_pkg::LANE_SAT].den)
        else $error("divider remainder out of range");

    // The lightness divisor is fixed and must never be corrupted in flight.
    a_lig_den: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[rhsl_pkg::STG_DIV_LAST]
        |-> lane_reg[rhsl_pkg::STG_DIV_LAST][rhsl_pkg::LANE_LIG].den == rhsl_pkg::LIG_DEN)
        else $error("lightness divisor corrupted");
`endif

endmodule
